FILE: rtl/core/coordinated_step_pulse_generator_macros.svh
// Assertion macros used by the step pulse generator checker.
`ifndef COORDINATED_STEP_PULSE_GENERATOR_MACROS_SVH
`define COORDINATED_STEP_PULSE_GENERATOR_MACROS_SVH
// Same-cycle implication, clocked on clk, held off during reset.
`define CSP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("step pulse generator check failed");
// Next-cycle implication, clocked on clk, held off during reset.
`define CSP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("step pulse generator check failed");
`endif

FILE: rtl/core/csp_pkg.sv
// Types and constants of the coordinated step pulse generator.
`timescale 1ns / 1ps
package csp_pkg;

	localparam int NAXES     = 4;
	localparam int TICK_RATE = 100000;
	localparam int DIV_W     = 32;
	localparam int SQ_W      = 17;
	localparam int HALF_W    = 24;
	localparam int CFG_IDX_W = 2;

	localparam logic [HALF_W-1:0] MIN_HALF = 24'd2;
	localparam logic [HALF_W-1:0] MAX_HALF = 24'hFFFFFF;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_MOVE = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd1;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SETTLE,
		PH_RUN
	} phase_t;

	typedef enum logic [1:0] {
		DS_SQRT,
		DS_CORR,
		DS_TOTAL,
		DS_AXIS
	} div_sel_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic signed [7:0] steps_axis0;
		logic signed [7:0] steps_axis1;
		logic signed [7:0] steps_axis2;
		logic signed [7:0] steps_axis3;
	} cmd_t;

	typedef struct packed {
		logic [3:0] step_pins;
		logic [3:0] dir_pins;
		logic       drive_current_high;
		logic       busy_res;
		logic [5:0] queue_free;
		logic       move_dropped;
		logic       move_done;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic       accept;
		logic       tick;
		logic       enq;
		logic       stop;
		logic       pop_rd;
		logic       pop_load;
		logic       div_start;
		div_sel_t   div_sel;
		logic       sq_upd;
		logic       corr;
		logic       mul;
		logic       tot_load;
		logic       ax_load;
		logic       ax_min;
		logic [1:0] ax_idx;
		logic       pop_fin;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] opcode;
		logic       phase_idle;
		logic       q_nonempty;
		logic       v_zero;
		logic       div_done;
		logic       sq_cont;
		logic       best_gt1;
		logic       ax_div;
	} sts_t;

endpackage

FILE: rtl/core/csp_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module csp_div import csp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quot,
	output logic [DIV_W-1:0] rem
);

	localparam int CNT_W = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dvs_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   trial;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(DIV_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial[DIV_W]) begin
				rem_q <= shifted[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end else begin
				rem_q <= trial[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/core/csp_dp.sv
// Datapath: move queue, axis timers, move planning arithmetic.
`timescale 1ns / 1ps
module csp_dp import csp_pkg::*; #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_wdata,
	input  cmd_t                 cmd_in,
	input  ctl_t                 ctl,
	output sts_t                 sts,
	output res_t                 stat
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int FW = (CW > 6) ? CW : 6;

	logic [15:0] min_speed_q;
	logic [15:0] settle_ticks_q;

	logic [31:0]   mem [QUEUE_DEPTH];
	logic [31:0]   rd_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	cmd_t          item_q;

	logic [7:0]        steps_q [NAXES];
	logic [HALF_W-1:0] half_q  [NAXES];
	logic [HALF_W-1:0] cd_q    [NAXES];
	logic [NAXES-1:0]  pin_q;
	logic [NAXES-1:0]  dir_q;
	logic [NAXES-1:0]  run_q;
	phase_t            phase_q;
	logic [15:0]       settle_q;
	logic              stop_q;
	logic              cur_q;
	logic              dropped_q;
	logic              done_q;

	logic [SQ_W-1:0]  v_q;
	logic [SQ_W-1:0]  guess_q;
	logic [SQ_W-1:0]  best_q;
	logic [DIV_W-1:0] prod_q;
	logic [DIV_W-1:0] total_q;

	// tick next-state
	logic [7:0]        nx_steps [NAXES];
	logic [HALF_W-1:0] nx_cd    [NAXES];
	logic [NAXES-1:0]  nx_pin;
	logic [NAXES-1:0]  nx_run;
	logic [HALF_W-1:0] dec_cd;
	phase_t            nx_phase;
	logic [15:0]       nx_settle;
	logic [CW-1:0]     nx_count;
	logic [AW-1:0]     nx_head;
	logic              nx_stop;
	logic              nx_cur;
	logic              tick_done;
	logic              check;
	logic              armed;

	// pop decode
	logic [7:0]      mag [NAXES];
	logic [NAXES-1:0] neg;
	logic [SQ_W-1:0] sumsq;

	// divider
	logic             div_done;
	logic [DIV_W-1:0] div_quot;
	logic [DIV_W-1:0] div_rem;
	logic [DIV_W-1:0] div_a;
	logic [DIV_W-1:0] div_b;
	logic [SQ_W:0]    sq_sum;
	logic [SQ_W-1:0]  sq_next;
	logic [DIV_W-2:0] half_raw;
	logic [HALF_W-1:0] half_sat;

	logic [AW:0]     wsum;
	logic [AW-1:0]   waddr;
	logic [AW-1:0]   head_inc;
	logic [FW-1:0]   free_w;
	logic [7:0]      cmd_steps [NAXES];

	// the queued word comes from the held transaction, not the live port
	assign cmd_steps[0] = item_q.steps_axis0;
	assign cmd_steps[1] = item_q.steps_axis1;
	assign cmd_steps[2] = item_q.steps_axis2;
	assign cmd_steps[3] = item_q.steps_axis3;

	assign wsum     = {1'b0, head_q} + (AW+1)'(count_q);
	assign waddr    = (wsum >= (AW+1)'(QUEUE_DEPTH)) ? AW'(wsum - (AW+1)'(QUEUE_DEPTH))
		: wsum[AW-1:0];
	assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	always_comb begin
		for (int i = 0; i < NAXES; i++) begin
			neg[i] = rd_q[8*i+7];
			mag[i] = neg[i] ? 8'(-rd_q[8*i +: 8]) : rd_q[8*i +: 8];
		end
		sumsq = SQ_W'(16'(mag[0] * mag[0])) + SQ_W'(16'(mag[1] * mag[1]))
			+ SQ_W'(16'(mag[2] * mag[2])) + SQ_W'(16'(mag[3] * mag[3]));
	end

	// one timer tick while settling or running
	always_comb begin
		nx_steps  = steps_q;
		nx_cd     = cd_q;
		nx_pin    = pin_q;
		nx_run    = run_q;
		nx_phase  = phase_q;
		nx_settle = settle_q;
		nx_count  = count_q;
		nx_head   = head_q;
		nx_stop   = stop_q;
		nx_cur    = cur_q;
		tick_done = 1'b0;
		check     = 1'b0;
		dec_cd    = '0;
		unique case (phase_q)
			PH_SETTLE: begin
				if (settle_q != '0) begin
					nx_settle = settle_q - 1'b1;
				end else begin
					for (int i = 0; i < NAXES; i++) begin
						if (run_q[i] && steps_q[i] != '0) begin
							nx_pin[i] = 1'b1;
							nx_cd[i]  = half_q[i];
						end
					end
					nx_phase = PH_RUN;
					check    = 1'b1;
				end
			end
			PH_RUN: begin
				for (int i = 0; i < NAXES; i++) begin
					if (cd_q[i] != '0) begin
						dec_cd   = cd_q[i] - 1'b1;
						nx_cd[i] = dec_cd;
						if (dec_cd == '0) begin
							if (pin_q[i]) begin
								nx_pin[i] = 1'b0;
								if (steps_q[i] != '0)
									nx_steps[i] = steps_q[i] - 1'b1;
								if (run_q[i])
									nx_cd[i] = half_q[i];
							end else if (steps_q[i] != '0 && run_q[i]) begin
								nx_pin[i] = 1'b1;
								nx_cd[i]  = half_q[i];
							end
						end
					end
				end
				check = 1'b1;
			end
			default: ;
		endcase
		armed = 1'b0;
		for (int i = 0; i < NAXES; i++)
			armed = armed | (nx_cd[i] != '0);
		// finish the move when nothing is armed
		if (check && !armed) begin
			nx_run   = '0;
			nx_phase = PH_IDLE;
			if (stop_q) begin
				nx_count = '0;
				nx_head  = '0;
				nx_stop  = 1'b0;
			end
			if (nx_count == '0)
				nx_cur = 1'b0;
			tick_done = 1'b1;
		end
	end

	always_comb begin
		unique case (ctl.div_sel)
			DS_SQRT: begin
				div_a = DIV_W'(v_q);
				div_b = DIV_W'(guess_q);
			end
			DS_CORR: begin
				div_a = DIV_W'(v_q);
				div_b = DIV_W'(best_q);
			end
			DS_TOTAL: begin
				div_a = prod_q;
				div_b = (min_speed_q == '0) ? DIV_W'(1) : DIV_W'(min_speed_q);
			end
			default: begin
				div_a = total_q;
				div_b = DIV_W'(steps_q[ctl.ax_idx]);
			end
		endcase
	end

	csp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// Newton step, rounded up
	assign sq_sum  = (SQ_W+1)'(div_quot[SQ_W-1:0]) + (SQ_W+1)'(guess_q);
	assign sq_next = sq_sum[SQ_W:1] + SQ_W'(sq_sum[0]);

	assign half_raw = div_quot[DIV_W-1:1];
	assign half_sat = (half_raw > (DIV_W-1)'(MAX_HALF)) ? MAX_HALF
		: (half_raw < (DIV_W-1)'(MIN_HALF)) ? MIN_HALF : half_raw[HALF_W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.enq && count_q < CW'(QUEUE_DEPTH))
			mem[waddr] <= {cmd_steps[3], cmd_steps[2], cmd_steps[1], cmd_steps[0]};
		if (ctl.pop_rd)
			rd_q <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.accept)
			item_q <= cmd_in;
		if (ctl.pop_load) begin
			v_q     <= sumsq;
			guess_q <= sumsq;
			best_q  <= sumsq;
		end
		if (ctl.sq_upd && best_q > sq_next) begin
			best_q  <= sq_next;
			guess_q <= sq_next;
		end
		if (ctl.corr && div_quot == DIV_W'(best_q - 1'b1) && div_rem == '0)
			best_q <= best_q - 1'b1;
		if (ctl.mul)
			prod_q <= DIV_W'(best_q) * DIV_W'(TICK_RATE);
		if (ctl.tot_load)
			total_q <= div_quot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q    <= 16'd2400;
			settle_ticks_q <= 16'd5000;
			head_q    <= '0;
			count_q   <= '0;
			pin_q     <= '0;
			dir_q     <= '0;
			run_q     <= '0;
			phase_q   <= PH_IDLE;
			settle_q  <= '0;
			stop_q    <= 1'b0;
			cur_q     <= 1'b0;
			dropped_q <= 1'b0;
			done_q    <= 1'b0;
			for (int i = 0; i < NAXES; i++) begin
				steps_q[i] <= '0;
				half_q[i]  <= '0;
				cd_q[i]    <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MIN_SPEED)
					min_speed_q <= cfg_wdata;
				else if (cfg_index == CFG_SETTLE)
					settle_ticks_q <= cfg_wdata;
			end
			if (ctl.accept) begin
				dropped_q <= 1'b0;
				done_q    <= 1'b0;
			end
			if (ctl.tick) begin
				steps_q  <= nx_steps;
				cd_q     <= nx_cd;
				pin_q    <= nx_pin;
				run_q    <= nx_run;
				phase_q  <= nx_phase;
				settle_q <= nx_settle;
				count_q  <= nx_count;
				head_q   <= nx_head;
				stop_q   <= nx_stop;
				cur_q    <= nx_cur;
				done_q   <= tick_done;
			end
			if (ctl.enq) begin
				if (count_q < CW'(QUEUE_DEPTH))
					count_q <= count_q + 1'b1;
				else
					dropped_q <= 1'b1;
			end
			if (ctl.stop) begin
				run_q <= '0;
				if (phase_q == PH_IDLE) begin
					count_q <= '0;
					head_q  <= '0;
					stop_q  <= 1'b0;
					cur_q   <= 1'b0;
				end else begin
					stop_q <= 1'b1;
				end
			end
			if (ctl.pop_load) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
				pin_q   <= '0;
				for (int i = 0; i < NAXES; i++) begin
					steps_q[i] <= mag[i];
					cd_q[i]    <= '0;
					dir_q[i]   <= !neg[i] && rd_q[8*i +: 8] != '0;
					run_q[i]   <= mag[i] != '0;
				end
			end
			if (ctl.ax_load)
				half_q[ctl.ax_idx] <= half_sat;
			if (ctl.ax_min)
				half_q[ctl.ax_idx] <= MIN_HALF;
			if (ctl.pop_fin) begin
				cur_q    <= 1'b1;
				settle_q <= settle_ticks_q;
				phase_q  <= PH_SETTLE;
			end
		end
	end

	assign free_w = FW'(QUEUE_DEPTH) - FW'(count_q);

	always_comb begin
		stat.step_pins          = pin_q;
		stat.dir_pins           = dir_q;
		stat.drive_current_high = cur_q;
		stat.busy_res           = phase_q != PH_IDLE;
		stat.queue_free         = (free_w > FW'(63)) ? 6'd63 : free_w[5:0];
		stat.move_dropped       = dropped_q;
		stat.move_done          = done_q;
	end

	assign sts.opcode     = item_q.opcode;
	assign sts.phase_idle = phase_q == PH_IDLE;
	assign sts.q_nonempty = count_q != '0;
	assign sts.v_zero     = v_q == '0;
	assign sts.div_done   = div_done;
	assign sts.sq_cont    = best_q > sq_next;
	assign sts.best_gt1   = best_q > SQ_W'(1);
	assign sts.ax_div     = steps_q[ctl.ax_idx] != '0 && best_q != '0;

endmodule

FILE: rtl/core/csp_ctrl.sv
// Controller: sequences each transaction and the move planning steps.
`timescale 1ns / 1ps
module csp_ctrl import csp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  sts_t sts,
	output ctl_t ctl,
	output logic ready,
	output logic resp
);

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_RD, S_LOAD, S_SQ, S_SQW, S_CR, S_CRW,
		S_MUL, S_TD, S_TDW, S_AX, S_AXW, S_FIN, S_OUT
	} state_t;

	state_t     state_q;
	state_t     state_nx;
	logic [1:0] idx_q;
	logic [1:0] idx_nx;

	always_comb begin
		ctl          = '0;
		ctl.div_sel  = DS_SQRT;
		ctl.ax_idx   = idx_q;
		ctl.accept   = accept;
		state_nx     = state_q;
		idx_nx       = idx_q;
		unique case (state_q)
			S_IDLE: if (accept) state_nx = S_DEC;
			S_DEC: begin
				priority if (sts.opcode == OP_TICK && sts.phase_idle && sts.q_nonempty) begin
					state_nx = S_RD;
				end else if (sts.opcode == OP_TICK) begin
					ctl.tick = 1'b1;
					state_nx = S_OUT;
				end else if (sts.opcode == OP_MOVE) begin
					ctl.enq  = 1'b1;
					state_nx = S_OUT;
				end else if (sts.opcode == OP_STOP) begin
					ctl.stop = 1'b1;
					state_nx = S_OUT;
				end else begin
					state_nx = S_OUT;
				end
			end
			S_RD: begin
				ctl.pop_rd = 1'b1;
				state_nx   = S_LOAD;
			end
			S_LOAD: begin
				ctl.pop_load = 1'b1;
				state_nx     = S_SQ;
			end
			S_SQ: begin
				if (sts.v_zero) begin
					idx_nx   = '0;
					state_nx = S_AX;
				end else begin
					ctl.div_start = 1'b1;
					state_nx      = S_SQW;
				end
			end
			S_SQW: begin
				if (sts.div_done) begin
					ctl.sq_upd = 1'b1;
					state_nx   = sts.sq_cont ? S_SQ : S_CR;
				end
			end
			S_CR: begin
				if (sts.best_gt1) begin
					ctl.div_sel   = DS_CORR;
					ctl.div_start = 1'b1;
					state_nx      = S_CRW;
				end else begin
					state_nx = S_MUL;
				end
			end
			S_CRW: begin
				if (sts.div_done) begin
					ctl.corr = 1'b1;
					state_nx = S_MUL;
				end
			end
			S_MUL: begin
				ctl.mul  = 1'b1;
				state_nx = S_TD;
			end
			S_TD: begin
				ctl.div_sel   = DS_TOTAL;
				ctl.div_start = 1'b1;
				state_nx      = S_TDW;
			end
			S_TDW: begin
				if (sts.div_done) begin
					ctl.tot_load = 1'b1;
					idx_nx       = '0;
					state_nx     = S_AX;
				end
			end
			S_AX: begin
				ctl.div_sel = DS_AXIS;
				if (sts.ax_div) begin
					ctl.div_start = 1'b1;
					state_nx      = S_AXW;
				end else begin
					ctl.ax_min = 1'b1;
					idx_nx     = idx_q + 1'b1;
					state_nx   = (idx_q == 2'(NAXES - 1)) ? S_FIN : S_AX;
				end
			end
			S_AXW: begin
				ctl.div_sel = DS_AXIS;
				if (sts.div_done) begin
					ctl.ax_load = 1'b1;
					idx_nx      = idx_q + 1'b1;
					state_nx    = (idx_q == 2'(NAXES - 1)) ? S_FIN : S_AX;
				end
			end
			S_FIN: begin
				ctl.pop_fin = 1'b1;
				state_nx    = S_OUT;
			end
			S_OUT:   state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_nx;
			idx_q   <= idx_nx;
		end
	end

	assign ready = state_q == S_IDLE;
	assign resp  = state_q == S_OUT;

endmodule

FILE: rtl/core/coordinated_step_pulse_generator.sv
// Top level: four-axis step pulse generator with queued moves.
// A stop, a move entry or a plain tick goes from decode straight to the output state.
// A popping tick reads and loads the next move, finds its length by Newton steps,
// checks the root when it exceeds 1, scales it and divides it once per moving axis; a zero
// move skips to the axes. All divisions share the one serial divider; one transaction at a
// time, each once the last result is taken. Reset (arst_n low) empties queue, idles axes.
`timescale 1ns / 1ps
module coordinated_step_pulse_generator import csp_pkg::*; #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  cmd_t                 cmd,
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_wdata
);

	ctl_t ctl;
	sts_t sts;
	res_t stat;
	logic ready;
	logic resp;
	logic accept;
	logic res_valid_q;
	res_t res_q;

	assign cmd_stall = !ready || res_valid_q;
	assign accept    = cmd_valid && !cmd_stall;

	csp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.sts    (sts),
		.ctl    (ctl),
		.ready  (ready),
		.resp   (resp)
	);

	csp_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd_in    (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.stat      (stat)
	);

	// hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (resp) begin
			res_valid_q <= 1'b1;
		end else if (res_valid_q && !res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp)
			res_q <= stat;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/core/csp_chk.sv
// Port checker for the step pulse generator, bound to the top level.
`timescale 1ns / 1ps
`include "coordinated_step_pulse_generator_macros.svh"
module csp_chk import csp_pkg::*; #(
	parameter int QUEUE_DEPTH = 32
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_stall,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	`CSP_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res))
	`CSP_ASSERT_NXT(a_one_at_a_time, cmd_valid && !cmd_stall, cmd_stall)
	`CSP_ASSERT_IMP(a_idle_pins_low, res_valid && !res.busy_res, res.step_pins == 4'd0)
	`CSP_ASSERT_IMP(a_drop_when_full, res_valid && res.move_dropped, res.queue_free == 6'd0)
	`CSP_ASSERT_IMP(a_free_bound, res_valid && QUEUE_DEPTH < 63,
		res.queue_free <= 6'(QUEUE_DEPTH))

endmodule

bind coordinated_step_pulse_generator csp_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

FILE: tb/tb_coordinated_step_pulse_generator.sv
// Self-checking testbench for the coordinated step pulse generator.
`timescale 1ns / 1ps
module tb_coordinated_step_pulse_generator;
	import csp_pkg::*;

	localparam int QDEPTH     = 32;
	localparam int POP_CYCLES = 700;

	typedef struct {
		cmd_t c;
		bit   typed;
		res_t r;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_t                 cmd;
	logic                 res_valid;
	logic                 res_stall;
	res_t                 res;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_wdata;

	// predictor state
	logic [15:0]          cur_speed;
	logic [15:0]          cur_settle;
	logic [31:0]          move_store [QDEPTH];
	int unsigned          q_count;
	int unsigned          q_head;
	int unsigned          ax_remain [NAXES];
	int unsigned          half_per [NAXES];
	int unsigned          countdown [NAXES];
	bit                   pin_high [NAXES];
	bit                   dir_pos [NAXES];
	bit                   running [NAXES];
	phase_t               phase;
	int unsigned          settle_left;
	bit                   stop_pend;
	bit                   current_hi;

	res_t                 pending_res [$];
	int                   errors;
	int                   snd_idle_pct;
	int                   rcv_idle_pct;
	int                   n_res;
	int                   hold_left;
	bit                   hold_done;

	coordinated_step_pulse_generator #(.QUEUE_DEPTH(QDEPTH)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int unsigned length_root(int unsigned v);
		int unsigned guess;
		int unsigned best;
		int unsigned sum;
		guess = v;
		best = v;
		if (v == 0) return 0;
		for (int g = 0; g < 64; g++) begin
			sum = v / guess + guess;
			guess = sum / 2 + sum % 2;
			if (best > guess) best = guess;
			else break;
		end
		if (best > 1 && v / best == best - 1 && v % best == 0) best--;
		return best;
	endfunction

	task automatic pop_next_move();
		logic [31:0]     word;
		logic [7:0]      b;
		int unsigned     sumsq;
		int unsigned     len;
		longint unsigned total;
		longint unsigned h;
		word = move_store[q_head % QDEPTH];
		sumsq = 0;
		q_head = (q_head + 1) % QDEPTH;
		q_count--;
		for (int i = 0; i < NAXES; i++) begin
			b = word[8*i +: 8];
			ax_remain[i] = b[7] ? 256 - b : b;
			dir_pos[i] = !b[7] && b != 0;
			running[i] = ax_remain[i] != 0;
			pin_high[i] = 0;
			countdown[i] = 0;
			sumsq += ax_remain[i] * ax_remain[i];
		end
		len = length_root(sumsq);
		total = longint'(len) * TICK_RATE / ((cur_speed == 0) ? 1 : cur_speed);
		for (int i = 0; i < NAXES; i++) begin
			h = 0;
			if (ax_remain[i] != 0 && len != 0) h = total / ax_remain[i] / 2;
			if (h < MIN_HALF) h = MIN_HALF;
			if (h > MAX_HALF) h = MAX_HALF;
			half_per[i] = 32'(h);
		end
		current_hi = 1;
		settle_left = cur_settle;
		phase = PH_SETTLE;
	endtask

	task automatic end_move();
		for (int i = 0; i < NAXES; i++) running[i] = 0;
		phase = PH_IDLE;
		if (stop_pend) begin
			q_count = 0;
			q_head = 0;
			stop_pend = 0;
		end
		if (q_count == 0) current_hi = 0;
	endtask

	task automatic step_axes();
		for (int i = 0; i < NAXES; i++) begin
			if (countdown[i] == 0) continue;
			countdown[i]--;
			if (countdown[i] != 0) continue;
			if (pin_high[i]) begin
				pin_high[i] = 0;
				if (ax_remain[i] != 0) ax_remain[i]--;
				if (running[i]) countdown[i] = half_per[i];
			end else if (ax_remain[i] != 0 && running[i]) begin
				pin_high[i] = 1;
				countdown[i] = half_per[i];
			end
		end
	endtask

	task automatic timer_tick(output bit done);
		bit armed;
		done = 0;
		if (phase == PH_IDLE) begin
			if (q_count != 0) pop_next_move();
			return;
		end
		if (phase == PH_SETTLE) begin
			if (settle_left != 0) begin
				settle_left--;
				return;
			end
			for (int i = 0; i < NAXES; i++)
				if (running[i] && ax_remain[i] != 0) begin
					pin_high[i] = 1;
					countdown[i] = half_per[i];
				end
			phase = PH_RUN;
		end else begin
			step_axes();
		end
		armed = 0;
		for (int i = 0; i < NAXES; i++) if (countdown[i] != 0) armed = 1;
		if (!armed) begin
			end_move();
			done = 1;
		end
	endtask

	task automatic predict_status(input cmd_t c, output res_t r);
		bit dropped;
		bit done;
		dropped = 0;
		done = 0;
		case (c.opcode)
			OP_TICK: timer_tick(done);
			OP_MOVE: begin
				if (q_count < QDEPTH) begin
					move_store[(q_head + q_count) % QDEPTH] =
						{c.steps_axis3, c.steps_axis2, c.steps_axis1, c.steps_axis0};
					q_count++;
				end else begin
					dropped = 1;
				end
			end
			OP_STOP: begin
				for (int i = 0; i < NAXES; i++) running[i] = 0;
				if (phase == PH_IDLE) begin
					q_count = 0;
					q_head = 0;
					stop_pend = 0;
					current_hi = 0;
				end else begin
					stop_pend = 1;
				end
			end
			default: ;
		endcase
		for (int i = 0; i < NAXES; i++) begin
			r.step_pins[i] = pin_high[i];
			r.dir_pins[i] = dir_pos[i];
		end
		r.drive_current_high = current_hi;
		r.busy_res = phase != PH_IDLE;
		r.queue_free = 6'(QDEPTH - q_count);
		r.move_dropped = dropped;
		r.move_done = done;
	endtask

	task automatic report(string field, int got, int want);
		$display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	task automatic check_status(res_t got);
		res_t want;
		if (pending_res.size() == 0) begin
			report("unexpected transaction", 1, 0);
			return;
		end
		want = pending_res.pop_front();
		if (got.step_pins != want.step_pins) report("step_pins", got.step_pins, want.step_pins);
		if (got.dir_pins != want.dir_pins) report("dir_pins", got.dir_pins, want.dir_pins);
		if (got.drive_current_high != want.drive_current_high)
			report("drive_current_high", got.drive_current_high, want.drive_current_high);
		if (got.busy_res != want.busy_res) report("busy_res", got.busy_res, want.busy_res);
		if (got.queue_free != want.queue_free)
			report("queue_free", got.queue_free, want.queue_free);
		if (got.move_dropped != want.move_dropped)
			report("move_dropped", got.move_dropped, want.move_dropped);
		if (got.move_done != want.move_done) report("move_done", got.move_done, want.move_done);
	endtask

	// result side: random stall plus one long hold-off
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			check_status(res);
			n_res++;
			if (n_res == 400 && !hold_done) begin
				hold_left = 300;
				hold_done = 1;
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= $urandom_range(99) < rcv_idle_pct;
		end
	end

	function automatic cmd_t mk_cmd(logic [1:0] op, int s0, int s1, int s2, int s3);
		cmd_t c;
		c.opcode = op;
		c.steps_axis0 = 8'(s0);
		c.steps_axis1 = 8'(s1);
		c.steps_axis2 = 8'(s2);
		c.steps_axis3 = 8'(s3);
		return c;
	endfunction

	function automatic res_t idle_status(int free);
		res_t r;
		r = '0;
		r.queue_free = 6'(free);
		return r;
	endfunction

	function automatic int rand_count();
		if ($urandom_range(9) < 7) return int'($urandom_range(6)) - 3;
		return int'($urandom_range(255)) - 128;
	endfunction

	function automatic cmd_t rand_cmd();
		int p;
		p = $urandom_range(99);
		if (p < 70) return mk_cmd(OP_TICK, 0, 0, 0, 0) | cmd_t'($urandom() & 32'hFFFFFFFF);
		if (p < 96) return mk_cmd(OP_MOVE, rand_count(), rand_count(), rand_count(), rand_count());
		if (p < 99) return mk_cmd(OP_STOP, $urandom(), $urandom(), $urandom(), $urandom());
		return mk_cmd(2'd3, $urandom(), $urandom(), $urandom(), $urandom());
	endfunction

	task automatic send(cmd_t c, bit typed, res_t typed_res);
		int   gap;
		res_t r;
		gap = 0;
		while ($urandom_range(99) < snd_idle_pct) gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (!(cmd_valid && !cmd_stall));
		predict_status(c, r);
		pending_res.push_back(typed ? typed_res : r);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (POP_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MIN_SPEED) cur_speed = val;
		else cur_settle = val;
	endtask

	task automatic random_phase(int n, int snd, int rcv, logic [15:0] spd, logic [15:0] stl);
		cfg_write(CFG_MIN_SPEED, spd);
		cfg_write(CFG_SETTLE, stl);
		snd_idle_pct = snd;
		rcv_idle_pct = rcv;
		for (int k = 0; k < n; k++) begin
			// halfway through, a burst of moves overflows the queue
			if (k == n / 2)
				for (int j = 0; j < 36; j++)
					send(mk_cmd(OP_MOVE, rand_count(), rand_count(), 0, 1), 0, '0);
			send(rand_cmd(), 0, '0);
		end
		drain();
	endtask

	initial begin
		row_t rows [$];
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		errors = 0;
		n_res = 0;
		hold_left = 0;
		hold_done = 0;
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		cur_speed = 16'd2400;
		cur_settle = 16'd5000;
		q_count = 0;
		q_head = 0;
		for (int i = 0; i < NAXES; i++) begin
			ax_remain[i] = 0;
			half_per[i] = 0;
			countdown[i] = 0;
			pin_high[i] = 0;
			dir_pos[i] = 0;
			running[i] = 0;
		end
		phase = PH_IDLE;
		settle_left = 0;
		stop_pend = 0;
		current_hi = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// status rows at reset defaults: idle, empty queue
		rows.push_back('{mk_cmd(OP_TICK, 0, 0, 0, 0), 1, idle_status(32)});
		rows.push_back('{mk_cmd(2'd3, -1, -1, -1, -1), 1, idle_status(32)});
		rows.push_back('{mk_cmd(OP_STOP, 0, 0, 0, 0), 1, idle_status(32)});
		rows.push_back('{mk_cmd(OP_MOVE, 127, -128, 0, 1), 1, idle_status(31)});
		rows.push_back('{mk_cmd(OP_MOVE, -128, 127, -1, 0), 1, idle_status(30)});
		rows.push_back('{mk_cmd(OP_STOP, 0, 0, 0, 0), 1, idle_status(32)});
		foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].r);
		drain();

		cfg_write(CFG_MIN_SPEED, 16'hFFFF);
		cfg_write(CFG_SETTLE, 16'd2);
		rows.delete();
		// zero move finishes on the tick that starts the run
		rows.push_back('{mk_cmd(OP_MOVE, 0, 0, 0, 0), 0, '0});
		for (int i = 0; i < 5; i++) rows.push_back('{mk_cmd(OP_TICK, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk_cmd(OP_MOVE, 2, 0, -1, 0), 0, '0});
		rows.push_back('{mk_cmd(OP_MOVE, 1, 1, 1, 1), 0, '0});
		for (int i = 0; i < 6; i++) rows.push_back('{mk_cmd(OP_TICK, 0, 0, 0, 0), 0, '0});
		// stop mid-move: axes end at next expiry, queue flushed at move end
		rows.push_back('{mk_cmd(OP_STOP, 0, 0, 0, 0), 0, '0});
		for (int i = 0; i < 6; i++) rows.push_back('{mk_cmd(OP_TICK, 0, 0, 0, 0), 0, '0});
		foreach (rows[i]) send(rows[i].c, rows[i].typed, rows[i].r);
		drain();

		random_phase(320, 21, 47, 16'hFFFF, 16'd0);
		random_phase(320, 47, 21, 16'd20000, 16'd2);
		random_phase(320, 0, 0, 16'd65000, 16'd1);

		// slowest speed and longest settle, left settling at the end
		cfg_write(CFG_MIN_SPEED, 16'd1);
		cfg_write(CFG_SETTLE, 16'hFFFF);
		send(mk_cmd(OP_MOVE, -128, 127, 3, -7), 0, '0);
		send(mk_cmd(OP_MOVE, 0, 0, 0, 0), 0, '0);
		for (int i = 0; i < 20; i++) send(mk_cmd(OP_TICK, 0, 0, 0, 0), 0, '0);
		drain();

		if (errors == 0 && pending_res.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: coordinated_step_pulse_generator.f
+incdir+rtl/core
rtl/core/csp_pkg.sv
rtl/core/csp_div.sv
rtl/core/csp_dp.sv
rtl/core/csp_ctrl.sv
rtl/core/coordinated_step_pulse_generator.sv
rtl/core/csp_chk.sv
tb/tb_coordinated_step_pulse_generator.sv
